@@ src/pwd_pkg.sv @@
// ----------------------------------------------------------------------------
// pwd_pkg
// shared types and codes for the pipeline progress watchdog
// ----------------------------------------------------------------------------
package pwd_pkg;

  localparam int NUM_STAGES = 9;
  localparam int GEN_W      = 64;
  localparam int TIME_W     = 64;
  localparam int STAGE_W    = 4;
  localparam int CFG_IDX_W  = 2;

  // request kinds
  localparam logic REQ_RECORD = 1'b0;
  localparam logic REQ_POLL   = 1'b1;

  // stage codes
  localparam logic [STAGE_W-1:0] STG_NONE      = 4'd0;
  localparam logic [STAGE_W-1:0] STG_CAPTURE   = 4'd1;
  localparam logic [STAGE_W-1:0] STG_PUBLISH   = 4'd2;
  localparam logic [STAGE_W-1:0] STG_SUBMIT    = 4'd3;
  localparam logic [STAGE_W-1:0] STG_ENCODE    = 4'd4;
  localparam logic [STAGE_W-1:0] STG_WRITTEN   = 4'd5;
  localparam logic [STAGE_W-1:0] STG_RECEIVED  = 4'd6;
  localparam logic [STAGE_W-1:0] STG_DECODED   = 4'd7;
  localparam logic [STAGE_W-1:0] STG_COMMITTED = 4'd8;
  localparam logic [STAGE_W-1:0] STG_PRESENTED = 4'd9;

  // capture status codes that let a capture count
  localparam logic [2:0] CAP_COMPLETE = 3'd1;
  localparam logic [2:0] CAP_STARTED  = 3'd5;

  // watch events
  localparam logic [1:0] WATCH_NONE    = 2'd0;
  localparam logic [1:0] WATCH_STALL   = 2'd1;
  localparam logic [1:0] WATCH_RECOVER = 2'd2;

  // side select
  localparam logic SIDE_SENDER   = 1'b0;
  localparam logic SIDE_RECEIVER = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE_SELECT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STALL_THR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HARD_TO     = 2'd2;

  localparam logic [TIME_W-1:0] STALL_THR_RESET = 64'd100000;
  localparam logic [TIME_W-1:0] HARD_TO_RESET   = 64'd1000000;

  typedef struct packed {
    logic               req_type;
    logic [STAGE_W-1:0] stage_code;
    logic [GEN_W-1:0]   frame_gen;
    logic [TIME_W-1:0]  timestamp_us;
    logic [2:0]         capture_status;
    logic               image_ok;
  } in_item_t;

  typedef struct packed {
    logic               error_flag;
    logic [63:0]        event_number;
    logic [1:0]         watch_event;
    logic [STAGE_W-1:0] lagging_stage;
    logic [GEN_W-1:0]   lagging_frame;
    logic [TIME_W-1:0]  stalled_time_us;
    logic               hard_flag;
  } out_item_t;

  typedef struct packed {
    logic              side_select;
    logic [TIME_W-1:0] stall_thr_us;
    logic [TIME_W-1:0] hard_to_us;
  } cfg_t;

  typedef struct packed {
    logic [STAGE_W-1:0] stage;
    logic [GEN_W-1:0]   frame;
  } lag_info_t;

endpackage

@@ src/pipeline_progress_watchdog.sv @@
// ----------------------------------------------------------------------------
// pipeline_progress_watchdog
// stage generation tracker with stall, recovery and hard-timeout watch
// ----------------------------------------------------------------------------
//
//   channel  handshake             payload       direction
//   in       in_valid / in_stall   in_item_t     record or poll transaction in
//   out      out_valid / out_stall out_item_t    one result per transaction
//   cfg      cfg_valid / cfg_ready index + data  register writes, always ready
//
// an accepted transaction lands in the input register, is evaluated
// combinationally against the tracker state and moves into the result
// register: one transaction per cycle sustained while out_stall is low
// out_stall holds the result register and then the input register; in_stall
// rises only once both are occupied, so one transaction still enters behind
// a waiting result. rst_n is synchronous; all tracker state clears at once
// ----------------------------------------------------------------------------
module pipeline_progress_watchdog
  import pwd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  cfg_t cfg;

  assign cfg_ready = 1'b1;

  pwd_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // --------------------------------------------------------------------------
  // pipeline control
  // --------------------------------------------------------------------------
  logic      in_valid_r;
  in_item_t  in_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;

  logic advance;   // result register can take a new transaction
  logic fire;      // input register moves into the result register
  logic in_take;

  assign advance  = !out_valid_r || !out_stall;
  assign fire     = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_data;
    end
  end

  // --------------------------------------------------------------------------
  // tracker state
  // --------------------------------------------------------------------------
  logic [GEN_W-1:0]   gen_r [NUM_STAGES];
  logic [63:0]        evt_cnt_r;
  logic [STAGE_W-1:0] w_stage_r;
  logic [GEN_W-1:0]   w_frame_r;
  logic [TIME_W-1:0]  w_since_r;
  logic               stall_rep_r;
  logic               hard_rep_r;

  logic [63:0]        evt_cnt_nxt;
  logic [STAGE_W-1:0] w_stage_nxt;
  logic [GEN_W-1:0]   w_frame_nxt;
  logic [TIME_W-1:0]  w_since_nxt;
  logic               stall_rep_nxt;
  logic               hard_rep_nxt;
  logic               gen_we;
  logic [STAGE_W-1:0] gen_idx;
  out_item_t          res;

  // lag search runs on the stored generations every cycle
  lag_info_t lag;

  pwd_lag_find u_lag (
    .gen         (gen_r),
    .side_select (cfg.side_select),
    .lag         (lag)
  );

  // --------------------------------------------------------------------------
  // record path terms
  // --------------------------------------------------------------------------
  logic             rec_tracked;
  logic             rec_counts;
  logic             rec_adv;
  logic [GEN_W-1:0] rec_cur;
  logic             rec_regress;

  assign gen_idx     = STAGE_W'(in_item_r.stage_code - STG_CAPTURE);
  assign rec_tracked = (in_item_r.stage_code >= STG_CAPTURE) &&
                       (in_item_r.stage_code <= STG_PRESENTED);
  // capture only counts with a good status and a valid image
  assign rec_counts  = (in_item_r.stage_code != STG_CAPTURE) ||
                       (((in_item_r.capture_status == CAP_COMPLETE) ||
                         (in_item_r.capture_status == CAP_STARTED)) &&
                        in_item_r.image_ok);
  assign rec_adv     = rec_tracked && rec_counts && (in_item_r.frame_gen != '0);
  assign rec_cur     = rec_tracked ? gen_r[gen_idx] : '0;
  assign rec_regress = in_item_r.frame_gen < rec_cur;

  // --------------------------------------------------------------------------
  // poll path terms
  // --------------------------------------------------------------------------
  logic              poll_bad;
  logic              lag_changed;
  logic [TIME_W-1:0] elapsed;

  assign poll_bad    = (in_item_r.timestamp_us == '0) ||
                       (cfg.stall_thr_us == '0) ||
                       (cfg.hard_to_us < cfg.stall_thr_us);
  assign lag_changed = (lag.stage != w_stage_r) || (lag.frame != w_frame_r);
  // clock going back counts as no time elapsed
  assign elapsed     = (in_item_r.timestamp_us >= w_since_r) ?
                       (in_item_r.timestamp_us - w_since_r) : '0;

  // --------------------------------------------------------------------------
  // evaluation
  // --------------------------------------------------------------------------
  always_comb begin
    evt_cnt_nxt   = evt_cnt_r;
    w_stage_nxt   = w_stage_r;
    w_frame_nxt   = w_frame_r;
    w_since_nxt   = w_since_r;
    stall_rep_nxt = stall_rep_r;
    hard_rep_nxt  = hard_rep_r;
    gen_we        = 1'b0;
    res           = '0;

    if (in_item_r.req_type == REQ_RECORD) begin
      if (in_item_r.timestamp_us == '0) begin
        res.error_flag = 1'b1;
      end else if (rec_adv && rec_regress) begin
        res.error_flag = 1'b1;
      end else begin
        gen_we           = rec_adv;
        evt_cnt_nxt      = evt_cnt_r + 64'd1;
        res.event_number = evt_cnt_nxt;
      end
    end else begin
      if (poll_bad) begin
        res.error_flag = 1'b1;
      end else if (lag.stage == STG_NONE) begin
        // lag cleared, report recovery only after a reported stall
        if (stall_rep_r) begin
          res.watch_event     = WATCH_RECOVER;
          res.lagging_stage   = w_stage_r;
          res.lagging_frame   = w_frame_r;
          res.stalled_time_us = elapsed;
          stall_rep_nxt       = 1'b0;
          hard_rep_nxt        = 1'b0;
        end
        w_stage_nxt = STG_NONE;
        w_frame_nxt = '0;
        w_since_nxt = '0;
      end else if (lag_changed) begin
        // new lag, restart the watch silently
        w_stage_nxt   = lag.stage;
        w_frame_nxt   = lag.frame;
        w_since_nxt   = in_item_r.timestamp_us;
        stall_rep_nxt = 1'b0;
        hard_rep_nxt  = 1'b0;
      end else if (!stall_rep_r && (elapsed >= cfg.stall_thr_us)) begin
        stall_rep_nxt       = 1'b1;
        res.watch_event     = WATCH_STALL;
        res.lagging_stage   = lag.stage;
        res.lagging_frame   = lag.frame;
        res.stalled_time_us = elapsed;
      end else if (!hard_rep_r && (elapsed >= cfg.hard_to_us)) begin
        hard_rep_nxt = 1'b1;
      end
    end

    res.hard_flag = hard_rep_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        gen_r[i] <= '0;
      end
      evt_cnt_r   <= '0;
      w_stage_r   <= STG_NONE;
      w_frame_r   <= '0;
      w_since_r   <= '0;
      stall_rep_r <= 1'b0;
      hard_rep_r  <= 1'b0;
    end else if (fire) begin
      if (gen_we) begin
        gen_r[gen_idx] <= in_item_r.frame_gen;
      end
      evt_cnt_r   <= evt_cnt_nxt;
      w_stage_r   <= w_stage_nxt;
      w_frame_r   <= w_frame_nxt;
      w_since_r   <= w_since_nxt;
      stall_rep_r <= stall_rep_nxt;
      hard_rep_r  <= hard_rep_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

@@ src/pwd_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// pwd_cfg_regs
// configuration register file, unknown indexes are dropped
// ----------------------------------------------------------------------------
module pwd_cfg_regs
  import pwd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [63:0]          wr_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        CFG_SIDE_SELECT: cfg_nxt.side_select  = wr_data[0];
        CFG_STALL_THR:   cfg_nxt.stall_thr_us = wr_data;
        CFG_HARD_TO:     cfg_nxt.hard_to_us   = wr_data;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.side_select  <= SIDE_SENDER;
      cfg_r.stall_thr_us <= STALL_THR_RESET;
      cfg_r.hard_to_us   <= HARD_TO_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ src/pwd_lag_find.sv @@
// ----------------------------------------------------------------------------
// pwd_lag_find
// first stage behind its predecessor on the selected side
// ----------------------------------------------------------------------------
module pwd_lag_find
  import pwd_pkg::*;
(
  input  logic [GEN_W-1:0] gen [NUM_STAGES],
  input  logic             side_select,
  output lag_info_t        lag
);

  // array slots of each stage (stage code minus one)
  localparam int I_CAP = 0;
  localparam int I_PUB = 1;
  localparam int I_SUB = 2;
  localparam int I_ENC = 3;
  localparam int I_WRT = 4;
  localparam int I_RCV = 5;
  localparam int I_DEC = 6;
  localparam int I_CMT = 7;
  localparam int I_PRS = 8;

  always_comb begin
    lag.stage = STG_NONE;
    lag.frame = '0;
    if (side_select == SIDE_SENDER) begin
      if (gen[I_PUB] < gen[I_CAP]) begin
        lag.stage = STG_PUBLISH;
        lag.frame = gen[I_CAP];
      end else if (gen[I_SUB] < gen[I_PUB]) begin
        lag.stage = STG_SUBMIT;
        lag.frame = gen[I_PUB];
      end else if (gen[I_ENC] < gen[I_SUB]) begin
        lag.stage = STG_ENCODE;
        lag.frame = gen[I_SUB];
      end else if (gen[I_WRT] < gen[I_ENC]) begin
        lag.stage = STG_WRITTEN;
        lag.frame = gen[I_ENC];
      end
    end else begin
      if (gen[I_DEC] < gen[I_RCV]) begin
        lag.stage = STG_DECODED;
        lag.frame = gen[I_RCV];
      end else if (gen[I_CMT] < gen[I_DEC]) begin
        lag.stage = STG_COMMITTED;
        lag.frame = gen[I_DEC];
      end else if (gen[I_PRS] < gen[I_CMT]) begin
        lag.stage = STG_PRESENTED;
        lag.frame = gen[I_CMT];
      end
    end
  end

endmodule
